>>> rtl/core/rbsi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbsi_pkg
// Shared types, constants and helpers for the ray/box slab intersect block.
// ----------------------------------------------------------------------------
package rbsi_pkg;

  localparam int CoordWidth = 32;
  localparam int FracBits   = 16;
  localparam int NumAxes    = 3;
  localparam int DiffWidth  = CoordWidth + 1;
  localparam int ProdWidth  = DiffWidth + CoordWidth;
  localparam int ShiftWidth = ProdWidth - FracBits;
  localparam int CfgIdxWidth = 3;

  typedef logic signed [CoordWidth-1:0] coord_t;
  typedef logic signed [DiffWidth-1:0]  diff_t;
  typedef logic signed [ProdWidth-1:0]  prod_t;
  typedef logic [$clog2(NumAxes)-1:0]   axis_t;

  // register indexes of the configuration port
  typedef enum logic [CfgIdxWidth-1:0] {
    RegBoxMinX = 3'd0,
    RegBoxMinY = 3'd1,
    RegBoxMinZ = 3'd2,
    RegBoxMaxX = 3'd3,
    RegBoxMaxY = 3'd4,
    RegBoxMaxZ = 3'd5
  } cfg_reg_e;

  localparam coord_t CoordMax = {1'b0, {(CoordWidth-1){1'b1}}};
  localparam coord_t CoordMin = {1'b1, {(CoordWidth-1){1'b0}}};
  // -1.0 in Q16.16, reported on a miss
  localparam coord_t TMiss = {{(CoordWidth-FracBits){1'b1}}, {FracBits{1'b0}}};

  typedef struct packed {
    coord_t origin_x;
    coord_t origin_y;
    coord_t origin_z;
    coord_t inv_dir_x;
    coord_t inv_dir_y;
    coord_t inv_dir_z;
    coord_t t_start;
    coord_t t_stop;
  } ray_t;

  typedef struct packed {
    logic   hit;
    coord_t t_enter;
    coord_t t_exit;
  } result_t;

  function automatic coord_t axis_origin(ray_t r, axis_t a);
    coord_t v;
    case (a)
      2'd0:    v = r.origin_x;
      2'd1:    v = r.origin_y;
      default: v = r.origin_z;
    endcase
    return v;
  endfunction

  function automatic coord_t axis_inv_dir(ray_t r, axis_t a);
    coord_t v;
    case (a)
      2'd0:    v = r.inv_dir_x;
      2'd1:    v = r.inv_dir_y;
      default: v = r.inv_dir_z;
    endcase
    return v;
  endfunction

  // floor(p / 2^FracBits), clamped to the coordinate range
  function automatic coord_t scale_sat(prod_t p);
    logic [ShiftWidth-1:0]           s;
    logic [ShiftWidth-CoordWidth:0]  top;
    coord_t                          v;
    s   = p[ProdWidth-1:FracBits];
    top = s[ShiftWidth-1:CoordWidth-1];
    if ((&top) || !(|top)) begin
      v = coord_t'(s[CoordWidth-1:0]);
    end else if (s[ShiftWidth-1]) begin
      v = CoordMin;
    end else begin
      v = CoordMax;
    end
    return v;
  endfunction

endpackage

>>> rtl/core/ray_box_slab_intersect.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_box_slab_intersect
// Slab test of one ray against the box held in the corner registers.
//
//   channel  signals                            direction
//   in       in_valid_i/in_ready_o/in_data_i     ray, inverse dir, interval
//   out      out_valid_o/out_ready_i/out_data_o  hit, t_enter, t_exit
//   cfg      cfg_we_i/cfg_idx_i/cfg_data_i       box corner write
//
// One ray per cycle unless stalled; three axis cells of three stages
// each (subtract, multiply, clamp and narrow) and the result register.
// Reset clears the box corners to zero and empties the pipeline.
// Each stage holds its transaction only while the stage after it is full
// and stalled: in a stall, input flows on until the bubbles have closed up.
// ----------------------------------------------------------------------------
module ray_box_slab_intersect (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  rbsi_pkg::ray_t                      in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output rbsi_pkg::result_t                   out_data_o,
  input  logic                               cfg_we_i,
  input  logic [rbsi_pkg::CfgIdxWidth-1:0]    cfg_idx_i,
  input  rbsi_pkg::coord_t                    cfg_data_i
);
  import rbsi_pkg::*;

  coord_t box_lo_q [NumAxes];
  coord_t box_hi_q [NumAxes];

  logic [NumAxes:0] vld;
  logic [NumAxes:0] rdy;
  ray_t             ray [NumAxes+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < NumAxes; a++) begin
        box_lo_q[a] <= '0;
        box_hi_q[a] <= '0;
      end
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        RegBoxMinX: box_lo_q[0] <= cfg_data_i;
        RegBoxMinY: box_lo_q[1] <= cfg_data_i;
        RegBoxMinZ: box_lo_q[2] <= cfg_data_i;
        RegBoxMaxX: box_hi_q[0] <= cfg_data_i;
        RegBoxMaxY: box_hi_q[1] <= cfg_data_i;
        RegBoxMaxZ: box_hi_q[2] <= cfg_data_i;
        default: ; // drop writes to unused indexes
      endcase
    end
  end

  assign vld[0]     = in_valid_i;
  assign ray[0]     = in_data_i;
  assign in_ready_o = rdy[0];

  for (genvar a = 0; a < NumAxes; a++) begin : g_cell
    rbsi_axis_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (vld[a]),
      .in_ready_o  (rdy[a]),
      .in_ray_i    (ray[a]),
      .org_i       (axis_origin(ray[a], axis_t'(a))),
      .inv_i       (axis_inv_dir(ray[a], axis_t'(a))),
      .box_lo_i    (box_lo_q[a]),
      .box_hi_i    (box_hi_q[a]),
      .out_valid_o (vld[a+1]),
      .out_ready_i (rdy[a+1]),
      .out_ray_o   (ray[a+1])
    );
  end

  rbsi_result_stage u_result (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (vld[NumAxes]),
    .in_ready_o  (rdy[NumAxes]),
    .in_ray_i    (ray[NumAxes]),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> rtl/core/rbsi_axis_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbsi_axis_cell
// One slab of the test: distances to both box planes on one axis, then the
// interval carried in t_start/t_stop is narrowed. Three register stages.
// ----------------------------------------------------------------------------
module rbsi_axis_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  rbsi_pkg::ray_t   in_ray_i,
  input  rbsi_pkg::coord_t org_i,
  input  rbsi_pkg::coord_t inv_i,
  input  rbsi_pkg::coord_t box_lo_i,
  input  rbsi_pkg::coord_t box_hi_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output rbsi_pkg::ray_t   out_ray_o
);
  import rbsi_pkg::*;

  logic [2:0] vld_q;
  logic [2:0] adv;

  ray_t   ray0_q, ray1_q, ray2_q;
  diff_t  dlo_q, dhi_q;
  coord_t inv_q;
  prod_t  plo_q, phi_q;
  logic   neg_q;

  coord_t s_lo, s_hi, t0, t1;
  ray_t   ray2_d;

  // a stage takes new data when it is empty or its contents move on
  assign adv[2] = !vld_q[2] || out_ready_i;
  assign adv[1] = !vld_q[1] || adv[2];
  assign adv[0] = !vld_q[0] || adv[1];
  assign in_ready_o = adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) vld_q[0] <= in_valid_i;
      if (adv[1]) vld_q[1] <= vld_q[0];
      if (adv[2]) vld_q[2] <= vld_q[1];
    end
  end

  // stage 3: floor, clamp, order by direction sign, narrow the interval
  always_comb begin
    s_lo = scale_sat(plo_q);
    s_hi = scale_sat(phi_q);
    t0   = neg_q ? s_hi : s_lo;
    t1   = neg_q ? s_lo : s_hi;
    ray2_d = ray1_q;
    if (t0 > ray1_q.t_start) ray2_d.t_start = t0;
    if (t1 < ray1_q.t_stop)  ray2_d.t_stop  = t1;
  end

  always_ff @(posedge clk_i) begin
    if (adv[0] && in_valid_i) begin
      ray0_q <= in_ray_i;
      dlo_q  <= {box_lo_i[CoordWidth-1], box_lo_i} - {org_i[CoordWidth-1], org_i};
      dhi_q  <= {box_hi_i[CoordWidth-1], box_hi_i} - {org_i[CoordWidth-1], org_i};
      inv_q  <= inv_i;
    end
    if (adv[1] && vld_q[0]) begin
      ray1_q <= ray0_q;
      plo_q  <= prod_t'(dlo_q) * prod_t'(inv_q);
      phi_q  <= prod_t'(dhi_q) * prod_t'(inv_q);
      neg_q  <= inv_q[CoordWidth-1];
    end
    if (adv[2] && vld_q[1]) begin
      ray2_q <= ray2_d;
    end
  end

  assign out_valid_o = vld_q[2];
  assign out_ray_o   = ray2_q;

endmodule

>>> rtl/core/rbsi_result_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbsi_result_stage
// Hit decision on the narrowed interval and the output register.
// ----------------------------------------------------------------------------
module rbsi_result_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  rbsi_pkg::ray_t     in_ray_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output rbsi_pkg::result_t  out_data_o
);
  import rbsi_pkg::*;

  logic    vld_q;
  result_t res_q, res_d;

  assign in_ready_o = !vld_q || out_ready_i;

  always_comb begin
    res_d.hit = in_ray_i.t_stop > in_ray_i.t_start;
    if (res_d.hit) begin
      res_d.t_enter = in_ray_i.t_start;
      res_d.t_exit  = in_ray_i.t_stop;
    end else begin
      res_d.t_enter = TMiss;
      res_d.t_exit  = TMiss;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ready_o) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = vld_q;
  assign out_data_o  = res_q;

endmodule
